// File: src/cdta_pkg.sv
// Shared types and constants for the calendar date tenor adder.
package cdta_pkg;

  typedef struct packed {
    logic signed [22:0] start_days;
    logic signed [15:0] tenor_count;
    logic        [1:0]  tenor_unit_code;
    logic               subtract;
  } cdta_req_t;

  typedef struct packed {
    logic signed [22:0] result_days;
    logic               out_of_range;
  } cdta_rsp_t;

  localparam logic [1:0] UNIT_DAYS   = 2'd0;
  localparam logic [1:0] UNIT_WEEKS  = 2'd1;
  localparam logic [1:0] UNIT_MONTHS = 2'd2;
  localparam logic [1:0] UNIT_YEARS  = 2'd3;

  // 0000-01-01 and 9999-12-31
  localparam logic signed [22:0] MIN_DAY = -23'sd719528;
  localparam logic signed [22:0] MAX_DAY = 23'sd2932896;

  // Day of year at the first of a month, months counted from March.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] ms;
    case (mp)
      4'd0:    ms = 9'd0;
      4'd1:    ms = 9'd31;
      4'd2:    ms = 9'd61;
      4'd3:    ms = 9'd92;
      4'd4:    ms = 9'd122;
      4'd5:    ms = 9'd153;
      4'd6:    ms = 9'd184;
      4'd7:    ms = 9'd214;
      4'd8:    ms = 9'd245;
      4'd9:    ms = 9'd275;
      4'd10:   ms = 9'd306;
      4'd11:   ms = 9'd337;
      default: ms = 9'd0;
    endcase
    return ms;
  endfunction

endpackage

// File: src/calendar_date_tenor_adder.sv
// Pipelined date plus tenor adder (days, weeks, months, years).
//
//   channel | dir | handshake            | word
//   req     | in  | req_valid/req_ready  | cdta_req_t: start, count, unit, subtract
//   rsp     | out | rsp_valid/rsp_ready  | cdta_rsp_t: result days, out of range
//
// 18 register stages: one word enters per cycle while req_ready is high. The
// depth is set by the date split and join chain, with most constant divisions
// done as reciprocal multiplies. Reset clears only the stage valid bits.
// A stalled output holds its word; upstream stages keep moving into empty
// slots, so req_ready stays high while any stage is empty.
module calendar_date_tenor_adder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  cdta_pkg::cdta_req_t  req_word,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output cdta_pkg::cdta_rsp_t  rsp_word
);
  import cdta_pkg::*;

  localparam int NS = 17;

  localparam logic [23:0] ZP_BIAS     = 24'd4371893;   // 719468 plus 25 eras
  localparam logic [14:0] ERA_RECIP   = 15'd29398;     // floor(2^32 / 146097)
  localparam logic [17:0] ERA_DAYS    = 18'd146097;
  localparam logic [17:0] RECIP_1460  = 18'd183860;    // >> 28, exact below 2^18
  localparam logic [17:0] RECIP_365   = 18'd183860;    // >> 26, exact below 2^18
  localparam logic [9:0]  RECIP_YC    = 10'd656;       // >> 16, yoe / 100
  localparam logic [12:0] RECIP_153   = 13'd6854;      // >> 20
  localparam logic [17:0] DOE_B1      = 18'd36524;
  localparam logic [17:0] DOE_B2      = 18'd73048;
  localparam logic [17:0] DOE_B3      = 18'd109572;
  localparam logic [17:0] DOE_LAST    = 18'd146096;
  localparam logic [20:0] T_BIAS      = 21'd456000;    // keeps the month index positive
  localparam logic [21:0] RECIP_12    = 22'd2796203;   // >> 25, exact below 2^21
  localparam logic [16:0] Q_BIAS      = 17'd4000;      // year offset 44000, multiple of 400
  localparam logic [17:0] RECIP_100   = 18'd167773;    // >> 24, exact below 2^17
  localparam logic [26:0] DAY_BIAS    = 27'd16790139;
  localparam logic signed [26:0] RES_MIN = -27'sd719528;
  localparam logic signed [26:0] RES_MAX = 27'sd2932896;

  typedef struct packed {
    logic [1:0]  unit;
    logic [16:0] cnt;
    logic [23:0] dw;
    logic [23:0] zp;
    logic [5:0]  era;
    logic [18:0] rem;
    logic [17:0] doe;
    logic [6:0]  a;
    logic [2:0]  b;
    logic        c;
    logic [17:0] num;
    logic [8:0]  yoe;
    logic [17:0] base;
    logic [1:0]  ycent;
    logic [8:0]  doy;
    logic [3:0]  mp;
    logic [4:0]  dom;
    logic [14:0] yp;
    logic [19:0] addend;
    logic [20:0] t;
    logic [16:0] q;
    logic [3:0]  mp2;
    logic [16:0] yyo;
    logic [9:0]  yh;
    logic [25:0] days_o;
    logic [8:0]  mday;
    logic [26:0] res;
  } stage_t;

  stage_t       pipe [1:NS];
  stage_t       nxt  [1:NS];
  logic [NS:1]  vld;
  logic [NS:1]  vld_next;
  logic [NS:1]  go;
  logic         go_out;
  cdta_rsp_t    rsp_next;

  assign go_out    = !rsp_valid || rsp_ready;
  assign req_ready = go[1];
  assign vld_next  = {vld[NS-1:1], req_valid};

  // A stage may load when the output moves or some slot at or after it is empty.
  for (genvar k = 1; k <= NS; k++) begin : g_go
    assign go[k] = go_out || !(&vld[NS:k]);
  end

  always_comb begin
    logic [16:0] cnt_in;
    logic [19:0] cnt7;
    logic [38:0] era_prod;
    logic [23:0] era_mul;
    logic [35:0] p1460;
    logic [35:0] p365;
    logic [18:0] pyc;
    logic [10:0] mp_num;
    logic [23:0] mp_prod;
    logic [22:0] t_sum;
    logic [42:0] q_prod;
    logic [20:0] q12;
    logic [34:0] yh_prod;

    // stage 1: negate count, day/week sum, biased day number
    cnt_in = req_word.subtract ?
             (17'd0 - {req_word.tenor_count[15], req_word.tenor_count}) :
             {req_word.tenor_count[15], req_word.tenor_count};
    cnt7 = {cnt_in, 3'b000} - {{3{cnt_in[16]}}, cnt_in};
    nxt[1]      = '0;
    nxt[1].unit = req_word.tenor_unit_code;
    nxt[1].cnt  = cnt_in;
    nxt[1].dw   = {req_word.start_days[22], req_word.start_days} +
                  ((req_word.tenor_unit_code == UNIT_WEEKS) ?
                   {{4{cnt7[19]}}, cnt7} : {{7{cnt_in[16]}}, cnt_in});
    nxt[1].zp   = {req_word.start_days[22], req_word.start_days} + ZP_BIAS;

    // stage 2: era estimate, floor or one below
    nxt[2] = pipe[1];
    era_prod = 39'(pipe[1].zp) * 39'(ERA_RECIP);
    nxt[2].era = era_prod[37:32];

    // stage 3
    nxt[3] = pipe[2];
    era_mul = 24'(pipe[2].era) * 24'(ERA_DAYS);
    nxt[3].rem = 19'(pipe[2].zp - era_mul);

    // stage 4: era correction
    nxt[4] = pipe[3];
    if (pipe[3].rem >= 19'(ERA_DAYS)) begin
      nxt[4].era = pipe[3].era + 6'd1;
      nxt[4].doe = 18'(pipe[3].rem - 19'(ERA_DAYS));
    end else begin
      nxt[4].doe = pipe[3].rem[17:0];
    end

    // stage 5: leap corrections within the era
    nxt[5] = pipe[4];
    p1460 = 36'(pipe[4].doe) * 36'(RECIP_1460);
    nxt[5].a = p1460[34:28];
    nxt[5].b = 3'(pipe[4].doe >= DOE_B1) + 3'(pipe[4].doe >= DOE_B2) +
               3'(pipe[4].doe >= DOE_B3) + 3'(pipe[4].doe >= DOE_LAST);
    nxt[5].c = (pipe[4].doe == DOE_LAST);

    // stage 6
    nxt[6] = pipe[5];
    nxt[6].num = pipe[5].doe - 18'(pipe[5].a) + 18'(pipe[5].b) - 18'(pipe[5].c);

    // stage 7: year of era
    nxt[7] = pipe[6];
    p365 = 36'(pipe[6].num) * 36'(RECIP_365);
    nxt[7].yoe = p365[34:26];

    // stage 8
    nxt[8] = pipe[7];
    nxt[8].base = 18'(pipe[7].yoe) * 18'd365 + 18'(pipe[7].yoe[8:2]);
    pyc = 19'(pipe[7].yoe) * 19'(RECIP_YC);
    nxt[8].ycent = pyc[17:16];

    // stage 9: day of March-based year
    nxt[9] = pipe[8];
    nxt[9].doy = 9'(pipe[8].doe - pipe[8].base + 18'(pipe[8].ycent));

    // stage 10: March-based month
    nxt[10] = pipe[9];
    mp_num  = 11'(pipe[9].doy) * 11'd5 + 11'd2;
    mp_prod = 24'(mp_num) * 24'(RECIP_153);
    nxt[10].mp = mp_prod[23:20];

    // stage 11: day of month, biased year, month step
    nxt[11] = pipe[10];
    nxt[11].dom = 5'(pipe[10].doy - month_start(pipe[10].mp) + 9'd1);
    nxt[11].yp  = 15'(pipe[10].era) * 15'd400 + 15'(pipe[10].yoe);
    nxt[11].addend = (pipe[10].unit == UNIT_YEARS) ?
                     ({pipe[10].cnt, 3'b000} + {pipe[10].cnt[16], pipe[10].cnt, 2'b00}) :
                     {{3{pipe[10].cnt[16]}}, pipe[10].cnt};

    // stage 12: biased month index counted from March
    nxt[12] = pipe[11];
    t_sum = 23'(pipe[11].yp) * 23'd12 + 23'(pipe[11].mp) +
            {{3{pipe[11].addend[19]}}, pipe[11].addend} + 23'(T_BIAS);
    nxt[12].t = t_sum[20:0];

    // stage 13
    nxt[13] = pipe[12];
    q_prod = 43'(pipe[12].t) * 43'(RECIP_12);
    nxt[13].q = q_prod[41:25];

    // stage 14
    nxt[14] = pipe[13];
    q12 = 21'(pipe[13].q) * 21'd12;
    nxt[14].mp2 = 4'(pipe[13].t - q12);
    nxt[14].yyo = pipe[13].q - Q_BIAS;

    // stage 15
    nxt[15] = pipe[14];
    yh_prod = 35'(pipe[14].yyo) * 35'(RECIP_100);
    nxt[15].yh = yh_prod[33:24];

    // stage 16: days up to March 1 of the target year (biased)
    nxt[16] = pipe[15];
    nxt[16].days_o = 26'(pipe[15].yyo) * 26'd365 + 26'(pipe[15].yyo[16:2]) -
                     26'(pipe[15].yh) + 26'(pipe[15].yh[9:2]);
    nxt[16].mday = month_start(pipe[15].mp2) + 9'(pipe[15].dom);

    // stage 17
    nxt[17] = pipe[16];
    if (pipe[16].unit inside {UNIT_DAYS, UNIT_WEEKS}) begin
      nxt[17].res = {{3{pipe[16].dw[23]}}, pipe[16].dw};
    end else begin
      nxt[17].res = 27'(pipe[16].days_o) + 27'(pipe[16].mday) - DAY_BIAS;
    end
  end

  // output: saturate to years 0..9999
  always_comb begin
    if ($signed(pipe[NS].res) < RES_MIN) begin
      rsp_next.result_days  = MIN_DAY;
      rsp_next.out_of_range = 1'b1;
    end else if ($signed(pipe[NS].res) > RES_MAX) begin
      rsp_next.result_days  = MAX_DAY;
      rsp_next.out_of_range = 1'b1;
    end else begin
      rsp_next.result_days  = pipe[NS].res[22:0];
      rsp_next.out_of_range = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (go[k]) begin
          vld[k] <= vld_next[k];
        end
      end
      if (go_out) begin
        rsp_valid <= vld[NS];
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe[1] <= go[1] ? nxt[1] : pipe[1];
    for (int k = 2; k <= NS; k++) begin
      if (go[k]) begin
        pipe[k] <= nxt[k];
      end
    end
    if (go_out) begin
      rsp_word <= rsp_next;
    end
  end

endmodule

// File: src/cdta_checker.sv
// Port-level checks for the date tenor adder, bound to the top level.
module cdta_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input cdta_pkg::cdta_rsp_t  rsp_word
);
  import cdta_pkg::*;

  // stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
    else $error("rsp word changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp_valid set after reset");

  // empty output stage means the pipe can take a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("req_ready low with empty output");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ($signed(rsp_word.result_days) >= MIN_DAY) &&
                  ($signed(rsp_word.result_days) <= MAX_DAY))
    else $error("result outside years 0..9999");

  a_flag_saturates: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.out_of_range |->
      (rsp_word.result_days == MIN_DAY) || (rsp_word.result_days == MAX_DAY))
    else $error("out_of_range without saturated result");

endmodule

bind calendar_date_tenor_adder cdta_checker u_cdta_checker (.*);

// File: tb/tb_calendar_date_tenor_adder.sv
// Testbench for the date plus tenor adder: directed edge dates, random stream, scoreboard.
module tb_calendar_date_tenor_adder;
  timeunit 1ns;
  timeprecision 1ps;

  import cdta_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_WORDS = 1750;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 13;
  localparam int QUIET_LO     = 1000;
  localparam int QUIET_HI     = 1400;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_LEN     = 150;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  cdta_req_t req_word = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  cdta_rsp_t rsp_word;

  cdta_req_t pending_words[$];
  cdta_rsp_t expected_dates[$];
  int        fail_cnt = 0;
  int        cycle_cnt = 0;
  int        hold_left = 0;
  logic      quiet;

  calendar_date_tenor_adder dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  assign quiet = (cycle_cnt >= QUIET_LO) && (cycle_cnt < QUIET_HI);

  // ---------------------------------------------------------------- calendar math
  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
    return q;
  endfunction

  function automatic void civil_from_days(input longint z, output longint y,
                                          output longint m, output longint d);
    longint era, doe, yoe, doy, mp;
    z   = z + 719468;
    era = floor_div(z, 146097);
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  // linear in d: days past month end roll forward
  function automatic longint days_from_civil(input longint y, input longint m,
                                             input longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y = y - 1;
    era = floor_div(y, 400);
    yoe = y - era * 400;
    doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic cdta_rsp_t predict_shifted_date(input cdta_req_t w);
    cdta_rsp_t r;
    longint    start, cnt, res, y, m, d, total, ny, nm;
    start = $signed(w.start_days);
    cnt   = $signed(w.tenor_count);
    if (w.subtract) cnt = -cnt;
    case (w.tenor_unit_code)
      UNIT_DAYS:  res = start + cnt;
      UNIT_WEEKS: res = start + cnt * 7;
      UNIT_MONTHS: begin
        civil_from_days(start, y, m, d);
        total = y * 12 + (m - 1) + cnt;
        ny    = floor_div(total, 12);
        nm    = total - ny * 12 + 1;
        res   = days_from_civil(ny, nm, d);
      end
      default: begin
        civil_from_days(start, y, m, d);
        res = days_from_civil(y + cnt, m, d);
      end
    endcase
    r.out_of_range = 1'b0;
    if (res < longint'(MIN_DAY)) begin
      res = MIN_DAY;
      r.out_of_range = 1'b1;
    end else if (res > longint'(MAX_DAY)) begin
      res = MAX_DAY;
      r.out_of_range = 1'b1;
    end
    r.result_days = res[22:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus build
  function automatic cdta_req_t mk_req(input longint start, input longint cnt,
                                       input logic [1:0] unit, input logic sub);
    cdta_req_t w;
    w.start_days      = start[22:0];
    w.tenor_count     = cnt[15:0];
    w.tenor_unit_code = unit;
    w.subtract        = sub;
    return w;
  endfunction

  function automatic cdta_req_t random_req();
    longint start, cnt;
    int     sel;
    sel = $urandom_range(99);
    if (sel < 60)
      start = longint'($urandom_range(3652424)) + MIN_DAY;
    else if (sel < 75)
      start = $signed(23'($urandom()));
    else if (sel < 87)
      start = ($urandom_range(1) ? longint'(MIN_DAY) : longint'(MAX_DAY - 400))
              + $urandom_range(400);
    else
      // late days of a month, where month and year moves overflow
      start = days_from_civil($urandom_range(9999), $urandom_range(1, 12),
                              $urandom_range(28, 31));
    sel = $urandom_range(99);
    if (sel < 50)      cnt = longint'($urandom_range(80)) - 40;
    else if (sel < 75) cnt = longint'($urandom_range(6000)) - 3000;
    else               cnt = $signed(16'($urandom()));
    return mk_req(start, cnt, 2'($urandom_range(3)), 1'($urandom_range(1)));
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    logic      nxt_valid;
    cdta_req_t nxt_word;
    logic      sender_idle;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      nxt_valid   = req_valid;
      nxt_word    = req_word;
      sender_idle = !quiet && ($urandom_range(99) < IDLE_PCT);
      if (req_valid && req_ready) begin
        expected_dates.push_back(predict_shifted_date(req_word));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_words.size() != 0 && !sender_idle) begin
        nxt_word  = pending_words.pop_front();
        nxt_valid = 1'b1;
      end
      req_valid <= nxt_valid;
      req_word  <= nxt_word;
    end
  end

  // ---------------------------------------------------------------- receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (cycle_cnt == HOLD_AT) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    cdta_rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_dates.size() == 0) begin
          $error("unexpected result word: result_days %0d out_of_range %0b",
                 $signed(rsp_word.result_days), rsp_word.out_of_range);
          fail_cnt = fail_cnt + 1;
        end else begin
          want = expected_dates.pop_front();
          if (rsp_word.result_days !== want.result_days) begin
            $error("result_days expected %0d actual %0d",
                   $signed(want.result_days), $signed(rsp_word.result_days));
            fail_cnt = fail_cnt + 1;
          end
          if (rsp_word.out_of_range !== want.out_of_range) begin
            $error("out_of_range expected %0b actual %0b",
                   want.out_of_range, rsp_word.out_of_range);
            fail_cnt = fail_cnt + 1;
          end
        end
      end
      rsp_ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    // range ends, saturation both ways
    pending_words.push_back(mk_req(MIN_DAY, 0, UNIT_DAYS, 1'b0));
    pending_words.push_back(mk_req(MAX_DAY, 0, UNIT_DAYS, 1'b0));
    pending_words.push_back(mk_req(MAX_DAY, 1, UNIT_DAYS, 1'b0));
    pending_words.push_back(mk_req(MIN_DAY, 1, UNIT_DAYS, 1'b1));
    pending_words.push_back(mk_req(0, 32767, UNIT_DAYS, 1'b0));
    pending_words.push_back(mk_req(0, -32768, UNIT_DAYS, 1'b0));
    // most negative count negated to +32768
    pending_words.push_back(mk_req(0, -32768, UNIT_DAYS, 1'b1));
    pending_words.push_back(mk_req(0, 32767, UNIT_WEEKS, 1'b0));
    pending_words.push_back(mk_req(MIN_DAY, -32768, UNIT_WEEKS, 1'b0));
    // month end rolls into next month
    pending_words.push_back(mk_req(days_from_civil(2020, 1, 31), 1, UNIT_MONTHS, 1'b0));
    pending_words.push_back(mk_req(days_from_civil(2021, 1, 31), 1, UNIT_MONTHS, 1'b0));
    // leap day plus a year, minus four years
    pending_words.push_back(mk_req(days_from_civil(2020, 2, 29), 1, UNIT_YEARS, 1'b0));
    pending_words.push_back(mk_req(days_from_civil(2020, 2, 29), 4, UNIT_YEARS, 1'b1));
    pending_words.push_back(mk_req(days_from_civil(1999, 12, 15), 1, UNIT_MONTHS, 1'b0));
    pending_words.push_back(mk_req(days_from_civil(2000, 1, 15), -1, UNIT_MONTHS, 1'b0));
    pending_words.push_back(mk_req(0, 32767, UNIT_MONTHS, 1'b0));
    pending_words.push_back(mk_req(0, -32768, UNIT_MONTHS, 1'b0));
    pending_words.push_back(mk_req(0, 32767, UNIT_YEARS, 1'b0));
    pending_words.push_back(mk_req(0, -32768, UNIT_YEARS, 1'b1));
    // start dates outside years 0..9999, moves past the range ends, a zero-month shift
    pending_words.push_back(mk_req(-4194304, 0, UNIT_DAYS, 1'b0));
    pending_words.push_back(mk_req(4194303, 0, UNIT_YEARS, 1'b0));
    pending_words.push_back(mk_req(4194303, -1, UNIT_MONTHS, 1'b1));
    pending_words.push_back(mk_req(MAX_DAY, 1, UNIT_YEARS, 1'b0));
    pending_words.push_back(mk_req(MIN_DAY, 1, UNIT_MONTHS, 1'b1));
    pending_words.push_back(mk_req(days_from_civil(2000, 2, 29), 0, UNIT_MONTHS, 1'b0));
    for (int i = 0; i < RANDOM_WORDS; i++)
      pending_words.push_back(random_req());

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || req_valid) @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
